/* rtl/riscx_pkg.sv */
// ============================================================================
// riscx_pkg: shared types and constants for the integer execute unit
// Holds opcode, function and status codes used by the unit and its helpers.
// ============================================================================
package riscx_pkg;

    // Result status codes.
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_OVF     = 3'd1;
    localparam logic [2:0] ST_ADDR    = 3'd2;
    localparam logic [2:0] ST_RSV     = 3'd3;
    localparam logic [2:0] ST_MEM     = 3'd4;

    localparam logic [31:0] REGION_MASK = 32'hF000_0000;
    localparam logic [31:0] SIGN_FILL   = 32'hFFFF_0000;
    localparam logic [31:0] RESET_PC    = 32'h1000_0000;

    // Primary opcodes.
    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_REGIMM  = 6'h01;
    localparam logic [5:0] OP_J       = 6'h02;
    localparam logic [5:0] OP_JAL     = 6'h03;
    localparam logic [5:0] OP_BEQ     = 6'h04;
    localparam logic [5:0] OP_BNE     = 6'h05;
    localparam logic [5:0] OP_BLEZ    = 6'h06;
    localparam logic [5:0] OP_BGTZ    = 6'h07;
    localparam logic [5:0] OP_ADDI    = 6'h08;
    localparam logic [5:0] OP_ADDIU   = 6'h09;
    localparam logic [5:0] OP_SLTI    = 6'h0A;
    localparam logic [5:0] OP_SLTIU   = 6'h0B;
    localparam logic [5:0] OP_ANDI    = 6'h0C;
    localparam logic [5:0] OP_ORI     = 6'h0D;
    localparam logic [5:0] OP_XORI    = 6'h0E;
    localparam logic [5:0] OP_LUI     = 6'h0F;
    localparam logic [5:0] OP_LB      = 6'h20;
    localparam logic [5:0] OP_LH      = 6'h21;
    localparam logic [5:0] OP_LWL     = 6'h22;
    localparam logic [5:0] OP_LW      = 6'h23;
    localparam logic [5:0] OP_LBU     = 6'h24;
    localparam logic [5:0] OP_LHU     = 6'h25;
    localparam logic [5:0] OP_LWR     = 6'h26;
    localparam logic [5:0] OP_SB      = 6'h28;
    localparam logic [5:0] OP_SH      = 6'h29;
    localparam logic [5:0] OP_SW      = 6'h2B;

    // SPECIAL function codes.
    localparam logic [5:0] FN_SLL   = 6'h00;
    localparam logic [5:0] FN_SRL   = 6'h02;
    localparam logic [5:0] FN_SRA   = 6'h03;
    localparam logic [5:0] FN_SLLV  = 6'h04;
    localparam logic [5:0] FN_SRLV  = 6'h06;
    localparam logic [5:0] FN_SRAV  = 6'h07;
    localparam logic [5:0] FN_JR    = 6'h08;
    localparam logic [5:0] FN_JALR  = 6'h09;
    localparam logic [5:0] FN_MFHI  = 6'h10;
    localparam logic [5:0] FN_MTHI  = 6'h11;
    localparam logic [5:0] FN_MFLO  = 6'h12;
    localparam logic [5:0] FN_MTLO  = 6'h13;
    localparam logic [5:0] FN_MULT  = 6'h18;
    localparam logic [5:0] FN_MULTU = 6'h19;
    localparam logic [5:0] FN_DIV   = 6'h1A;
    localparam logic [5:0] FN_DIVU  = 6'h1B;
    localparam logic [5:0] FN_ADD   = 6'h20;
    localparam logic [5:0] FN_ADDU  = 6'h21;
    localparam logic [5:0] FN_SUB   = 6'h22;
    localparam logic [5:0] FN_SUBU  = 6'h23;
    localparam logic [5:0] FN_AND   = 6'h24;
    localparam logic [5:0] FN_OR    = 6'h25;
    localparam logic [5:0] FN_XOR   = 6'h26;
    localparam logic [5:0] FN_NOR   = 6'h27;
    localparam logic [5:0] FN_SLT   = 6'h2A;
    localparam logic [5:0] FN_SLTU  = 6'h2B;

    // REGIMM rt codes.
    localparam logic [4:0] RI_BLTZ   = 5'h00;
    localparam logic [4:0] RI_BGEZ   = 5'h01;
    localparam logic [4:0] RI_BLTZAL = 5'h10;
    localparam logic [4:0] RI_BGEZAL = 5'h11;

    // Request to the multiply/divide unit.
    typedef struct packed {
        logic        start;
        logic        is_div;
        logic        is_signed;
        logic [31:0] a;
        logic [31:0] b;
    } t_md_req;

    // Response from the multiply/divide unit.
    typedef struct packed {
        logic        done;
        logic [31:0] hi;
        logic [31:0] lo;
    } t_md_rsp;

endpackage

/* rtl/riscx_if.sv */
// ============================================================================
// riscx_if: valid/ready channel carrying a generic payload
// One beat moves when valid and ready are both high at a rising edge.
// ============================================================================
interface riscx_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/riscx_muldiv.sv */
// ============================================================================
// riscx_muldiv: radix-2 iterative multiply and divide unit
// Works on magnitudes one bit per cycle, then fixes the signs of the results.
// ============================================================================
module riscx_muldiv (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  riscx_pkg::t_md_req  i_req,
    output riscx_pkg::t_md_rsp  o_rsp
);
    import riscx_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_FIX  = 3'b100
    } t_state;

    t_state      r_state;
    logic [4:0]  r_cnt;
    logic        r_div;
    logic        r_neg_q;
    logic        r_neg_r;
    logic [31:0] r_mcand;      // multiplicand or divisor magnitude
    logic [63:0] r_acc;        // {hi, lo} working register
    logic [32:0] w_sub;
    logic [32:0] w_add;

    logic        w_na, w_nb;
    assign w_na = i_req.is_signed & i_req.a[31];
    assign w_nb = i_req.is_signed & i_req.b[31];

    assign w_sub = {r_acc[63:31]} - {1'b0, r_mcand};
    assign w_add = {1'b0, r_acc[63:32]} + {1'b0, r_mcand};

    // Sequencer: one quotient or product bit per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.start) begin
                        r_state <= S_RUN;
                        r_cnt   <= '0;
                    end
                end
                S_RUN: begin
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd31) begin
                        r_state <= S_FIX;
                    end
                end
                S_FIX: begin
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_div   <= i_req.is_div;
                r_neg_q <= w_na ^ w_nb;
                r_neg_r <= w_na;
                r_mcand <= w_nb ? (32'd0 - i_req.b) : i_req.b;
                r_acc   <= {32'd0, (w_na ? (32'd0 - i_req.a) : i_req.a)};
            end
            S_RUN: begin
                if (r_div) begin
                    if (!w_sub[32]) begin
                        r_acc <= {w_sub[31:0], r_acc[30:0], 1'b1};
                    end else begin
                        r_acc <= {r_acc[62:0], 1'b0};
                    end
                end else begin
                    if (r_acc[0]) begin
                        r_acc <= {w_add, r_acc[31:1]};
                    end else begin
                        r_acc <= {1'b0, r_acc[63:1]};
                    end
                end
            end
            S_FIX: begin
                if (r_div) begin
                    if (r_neg_q) r_acc[31:0]  <= 32'd0 - r_acc[31:0];
                    if (r_neg_r) r_acc[63:32] <= 32'd0 - r_acc[63:32];
                end else if (r_neg_q) begin
                    r_acc <= 64'd0 - r_acc;
                end
            end
            default: ;
        endcase
    end

    assign o_rsp.done = (r_state == S_IDLE);
    assign o_rsp.hi   = r_acc[63:32];
    assign o_rsp.lo   = r_acc[31:0];
endmodule

/* rtl/risc_integer_execute_unit.sv */
// ============================================================================
// risc_integer_execute_unit: integer execute stage with register file
// Decodes and executes one instruction word per beat and returns one result.
// ============================================================================
// An instruction is taken, its operands are read from the register file in the
// next cycle, it is executed and committed in the EXEC state, and the result
// beat is offered from an output register; the unit accepts the next
// instruction once that result has been taken. Multiply and divide run on a
// shared one-bit-per-cycle unit. Writing reset_pc reloads the PC chain.
module risc_integer_execute_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    riscx_if.sink       in_if,
    riscx_if.source     out_if,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import riscx_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_READ = 5'b00010,
        S_EXEC = 5'b00100,
        S_MD   = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state      r_state;
    logic [31:0] r_reset_pc;
    logic [31:0] r_pc, r_pc_ds, r_pc_as;
    logic [31:0] r_hi, r_lo;
    logic [31:0] r_regs [32];
    logic [31:0] r_word;
    logic [31:0] r_a, r_b;
    logic [2:0]  r_status;
    logic        r_we;
    logic [4:0]  r_dest;
    logic [31:0] r_val, r_fetch, r_acc;

    t_md_req     w_req;
    t_md_rsp     w_rsp;

    logic        w_cfg_wr;
    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite & (paddr == 2'd0);
    assign prdata   = (paddr == 2'd0) ? r_reset_pc : 32'd0;

    // Instruction fields.
    logic [5:0]  w_op, w_fn;
    logic [4:0]  w_rs, w_rt, w_rd, w_sh;
    logic [31:0] w_imm, w_simm, w_seq, w_link, w_btgt;
    assign w_op   = r_word[31:26];
    assign w_rs   = r_word[25:21];
    assign w_rt   = r_word[20:16];
    assign w_rd   = r_word[15:11];
    assign w_sh   = r_word[10:6];
    assign w_fn   = r_word[5:0];
    assign w_imm  = {16'd0, r_word[15:0]};
    assign w_simm = r_word[15] ? (SIGN_FILL | w_imm) : w_imm;
    assign w_seq  = r_pc + 32'd4;
    assign w_link = r_pc + 32'd8;
    assign w_btgt = w_seq + {w_simm[29:0], 2'b00};

    // Decode and execute, combinational.
    logic [2:0]  n_status;
    logic        n_wr, n_taken, n_hand, n_md, n_mthi, n_mtlo;
    logic [4:0]  n_dest;
    logic [31:0] n_val, n_tgt, n_acc, w_r, w_shb;
    logic [4:0]  w_amt;
    always_comb begin
        n_status = ST_OK;
        n_wr     = 1'b0;
        n_taken  = 1'b0;
        n_hand   = 1'b0;
        n_md     = 1'b0;
        n_mthi   = 1'b0;
        n_mtlo   = 1'b0;
        n_dest   = 5'd0;
        n_val    = 32'd0;
        n_tgt    = w_btgt;
        n_acc    = 32'd0;
        w_r      = 32'd0;
        w_amt    = w_fn[2] ? r_a[4:0] : w_sh;
        w_shb    = 32'd0;
        case (w_op)
            OP_SPECIAL: begin
                n_dest = w_rd;
                case (w_fn)
                    FN_SLL, FN_SLLV: begin n_val = r_b << w_amt; n_wr = 1'b1; end
                    FN_SRL, FN_SRLV: begin n_val = r_b >> w_amt; n_wr = 1'b1; end
                    FN_SRA, FN_SRAV: begin
                        w_shb = $unsigned($signed(r_b) >>> w_amt);
                        n_val = w_shb;
                        n_wr  = 1'b1;
                    end
                    FN_JR, FN_JALR: begin
                        if (r_a[1:0] != 2'b00) begin
                            n_status = ST_ADDR;
                        end else begin
                            n_taken = 1'b1;
                            n_tgt   = r_a;
                            if (w_fn == FN_JALR) begin
                                n_val = w_link;
                                n_wr  = 1'b1;
                            end
                        end
                    end
                    FN_MFHI: begin n_val = r_hi; n_wr = 1'b1; end
                    FN_MFLO: begin n_val = r_lo; n_wr = 1'b1; end
                    FN_MTHI: n_mthi = 1'b1;
                    FN_MTLO: n_mtlo = 1'b1;
                    FN_MULT, FN_MULTU: n_md = 1'b1;
                    FN_DIV, FN_DIVU: n_md = (r_b != 32'd0);
                    FN_ADD: begin
                        w_r = r_a + r_b;
                        if ((r_a[31] == r_b[31]) && (w_r[31] != r_a[31])) begin
                            n_status = ST_OVF;
                        end else begin
                            n_val = w_r;
                            n_wr  = 1'b1;
                        end
                    end
                    FN_ADDU: begin n_val = r_a + r_b; n_wr = 1'b1; end
                    FN_SUB: begin
                        w_r = r_a - r_b;
                        if ((r_a[31] != r_b[31]) && (w_r[31] != r_a[31])) begin
                            n_status = ST_OVF;
                        end else begin
                            n_val = w_r;
                            n_wr  = 1'b1;
                        end
                    end
                    FN_SUBU: begin n_val = r_a - r_b; n_wr = 1'b1; end
                    FN_AND:  begin n_val = r_a & r_b; n_wr = 1'b1; end
                    FN_OR:   begin n_val = r_a | r_b; n_wr = 1'b1; end
                    FN_XOR:  begin n_val = r_a ^ r_b; n_wr = 1'b1; end
                    FN_NOR:  begin n_val = ~(r_a | r_b); n_wr = 1'b1; end
                    FN_SLT: begin
                        n_val = {31'd0, ($signed(r_a) < $signed(r_b))};
                        n_wr  = 1'b1;
                    end
                    FN_SLTU: begin n_val = {31'd0, (r_a < r_b)}; n_wr = 1'b1; end
                    default: n_status = ST_RSV;
                endcase
            end
            OP_REGIMM: begin
                unique case (w_rt)
                    RI_BLTZ, RI_BLTZAL: n_taken = r_a[31];
                    RI_BGEZ, RI_BGEZAL: n_taken = ~r_a[31];
                    default: n_status = ST_RSV;
                endcase
                if (n_status == ST_OK && w_rt[4]) begin
                    n_dest = 5'd31;
                    n_val  = w_link;
                    n_wr   = 1'b1;
                end
            end
            OP_J, OP_JAL: begin
                n_taken = 1'b1;
                n_tgt   = (w_seq & REGION_MASK) | {4'd0, r_word[25:0], 2'b00};
                if (w_op == OP_JAL) begin
                    n_dest = 5'd31;
                    n_val  = w_link;
                    n_wr   = 1'b1;
                end
            end
            OP_BEQ:  n_taken = (r_a == r_b);
            OP_BNE:  n_taken = (r_a != r_b);
            OP_BLEZ: n_taken = (r_a == 32'd0) || r_a[31];
            OP_BGTZ: n_taken = (r_a != 32'd0) && !r_a[31];
            OP_ADDI: begin
                w_r = r_a + w_simm;
                if ((r_a[31] == w_simm[31]) && (w_r[31] != r_a[31])) begin
                    n_status = ST_OVF;
                end else begin
                    n_dest = w_rt;
                    n_val  = w_r;
                    n_wr   = 1'b1;
                end
            end
            OP_ADDIU: begin n_dest = w_rt; n_val = r_a + w_simm; n_wr = 1'b1; end
            OP_SLTI: begin
                n_dest = w_rt;
                n_val  = {31'd0, ($signed(r_a) < $signed(w_simm))};
                n_wr   = 1'b1;
            end
            OP_SLTIU: begin n_dest = w_rt; n_val = {31'd0, (r_a < w_simm)}; n_wr = 1'b1; end
            OP_ANDI: begin n_dest = w_rt; n_val = r_a & w_imm; n_wr = 1'b1; end
            OP_ORI:  begin n_dest = w_rt; n_val = r_a | w_imm; n_wr = 1'b1; end
            OP_XORI: begin n_dest = w_rt; n_val = r_a ^ w_imm; n_wr = 1'b1; end
            OP_LUI:  begin n_dest = w_rt; n_val = {r_word[15:0], 16'd0}; n_wr = 1'b1; end
            OP_LB, OP_LH, OP_LWL, OP_LW, OP_LBU, OP_LHU, OP_LWR: begin
                n_status = ST_MEM;
                n_acc    = r_a + w_simm;
                n_hand   = 1'b1;
            end
            OP_SB, OP_SH, OP_SW: begin
                n_status = ST_MEM;
                n_acc    = r_a + w_simm;
            end
            default: n_status = ST_RSV;
        endcase
        // Writes to r0 are dropped.
        if (!(n_wr && n_dest != 5'd0)) begin
            n_wr   = 1'b0;
            n_val  = 32'd0;
            n_dest = n_hand ? w_rt : 5'd0;
        end
    end

    logic w_fault;
    assign w_fault = (n_status != ST_OK) && (n_status != ST_MEM);

    assign w_req.start     = (r_state == S_EXEC) && !w_fault && n_md;
    assign w_req.is_div    = w_fn[1];
    assign w_req.is_signed = ~w_fn[0];
    assign w_req.a         = r_a;
    assign w_req.b         = r_b;

    riscx_muldiv u_md (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign in_if.ready  = (r_state == S_IDLE);
    assign out_if.valid = (r_state == S_OUT);
    assign out_if.data  = {r_status, r_we, r_dest, r_val, r_fetch, r_acc};

    // Register file: one write port, read ports in the operand cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 32; k++) r_regs[k] <= 32'd0;
        end else if (r_state == S_EXEC && !w_fault && n_wr) begin
            r_regs[n_dest] <= n_val;
        end
    end

    // Sequencer and architectural state.
    logic [31:0] w_base;
    logic        w_md_wait;
    assign w_base = n_taken ? n_tgt : r_pc_as;
    logic [1:0] r_md_dly;
    assign w_md_wait = (r_md_dly != 2'd0) || !w_rsp.done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_reset_pc <= RESET_PC;
            r_pc       <= RESET_PC;
            r_pc_ds    <= RESET_PC + 32'd4;
            r_pc_as    <= RESET_PC + 32'd8;
            r_hi       <= 32'd0;
            r_lo       <= 32'd0;
            r_md_dly   <= 2'd0;
        end else begin
            if (w_cfg_wr) begin
                r_reset_pc <= pwdata;
                r_pc       <= pwdata;
                r_pc_ds    <= pwdata + 32'd4;
                r_pc_as    <= pwdata + 32'd8;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_if.valid) begin
                        r_word  <= in_if.data;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_a     <= r_regs[w_rs];
                    r_b     <= r_regs[w_rt];
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    r_status <= n_status;
                    if (w_fault) begin
                        r_we    <= 1'b0;
                        r_dest  <= 5'd0;
                        r_val   <= 32'd0;
                        r_acc   <= 32'd0;
                        r_fetch <= r_pc;
                        r_state <= S_OUT;
                    end else begin
                        r_we    <= n_wr;
                        r_dest  <= n_dest;
                        r_val   <= n_val;
                        r_acc   <= n_acc;
                        r_fetch <= r_pc_ds;
                        r_pc    <= r_pc_ds;
                        r_pc_ds <= w_base;
                        r_pc_as <= w_base + 32'd4;
                        if (n_mthi) r_hi <= r_a;
                        if (n_mtlo) r_lo <= r_a;
                        if (n_md) begin
                            r_md_dly <= 2'd2;
                            r_state  <= S_MD;
                        end else begin
                            r_state <= S_OUT;
                        end
                    end
                end
                S_MD: begin
                    if (r_md_dly != 2'd0) r_md_dly <= r_md_dly - 2'd1;
                    if (!w_md_wait) begin
                        r_hi    <= w_rsp.hi;
                        r_lo    <= w_rsp.lo;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_if.ready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

/* rtl/riscx_checker.sv */
// ============================================================================
// riscx_checker: port-level checks for the integer execute unit
// Watches the handshakes and result fields seen at the top level's ports.
// ============================================================================
module riscx_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_in_valid,
    input logic         i_in_ready,
    input logic         i_out_valid,
    input logic         i_out_ready,
    input logic [104:0] i_out_data
);
    import riscx_pkg::*;

    logic [2:0] w_st;
    assign w_st = i_out_data[104:102];

    // A result is held until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result beat dropped or changed while stalled");

    // No instruction is taken while a result is pending.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready)
        else $error("input ready while a result is pending");

    // An accepted instruction is not followed by ready in the next cycle.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("unit ready right after taking an instruction");

    // Faults never report a register write.
    a_fault_nowr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (w_st == ST_OVF || w_st == ST_ADDR || w_st == ST_RSV)
        |-> !i_out_data[101])
        else $error("faulting instruction reports a write");
endmodule

bind risc_integer_execute_unit riscx_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (in_if.valid),
    .i_in_ready  (in_if.ready),
    .i_out_valid (out_if.valid),
    .i_out_ready (out_if.ready),
    .i_out_data  (out_if.data)
);
